// ===== rtl/core/cda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg: shared types and tables for the calendar date analyzer
// Command/result structs, opcodes, month tables and reciprocal constants.
// ----------------------------------------------------------------------------
package cda_pkg;

	typedef enum logic [1:0] {
		OP_DIRECT = 2'd0,
		OP_PACKED = 2'd1,
		OP_CODED  = 2'd2
	} cda_op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
		logic [23:0] coded_date;
	} cda_cmd_t;

	typedef struct packed {
		logic        valid_res;
		logic        leap;
		logic [4:0]  month_length;
		logic [2:0]  weekday;
		logic [8:0]  year_day;
		logic [5:0]  week_of_year;
		logic [23:0] packed_date_out;
		logic [17:0] coded_date_out;
		logic [17:0] packed_time_out;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [8:0]  out_day;
	} cda_res_t;

	// decoded date handed from the source decoder to the calendar stages
	typedef struct packed {
		logic [14:0] year;
		logic [3:0]  month;
		logic [8:0]  day;
		logic        leap;
		logic [6:0]  ymod100;   // year % 100
		logic [7:0]  cent400;   // (year + 400) / 100
		logic        time_ok;
		logic [17:0] packed_time;
	} cda_dec_t;

	localparam logic [14:0] YEAR_MAX    = 15'd9999;
	localparam logic [14:0] YEAR_BASE19 = 15'd1900;
	localparam logic [14:0] YEAR_BASE20 = 15'd2000;
	localparam logic [14:0] YEAR_SHIFT  = 15'd400;
	localparam logic [3:0]  MONTH_OVF   = 4'd13;
	localparam logic [17:0] CENT_WEIGHT = 18'd100000;

	// floor(x/1000) = (x * RECIP_1000) >> 34, exact for 24-bit x
	localparam logic [24:0] RECIP_1000 = 25'd17179870;
	// floor(x/100)  = (x * RECIP_100) >> 20, exact for x < 20000
	localparam logic [13:0] RECIP_100  = 14'd10486;
	// floor(x/10)   = (x * RECIP_10) >> 11, exact for x < 256
	localparam logic [7:0]  RECIP_10   = 8'd205;
	// floor(x/7)    = (x * RECIP_7) >> 15, exact for x < 2048
	localparam logic [12:0] RECIP_7    = 13'd4682;

	function automatic logic [4:0] cda_month_days(input logic [3:0] m, input logic lp);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = lp ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// days before the first of month m, leap day included
	function automatic logic [8:0] cda_days_before(input logic [3:0] m, input logic lp);
		logic [8:0] base;
		case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((lp && m > 4'd2) ? 9'd1 : 9'd0);
	endfunction

	// Zeller month term floor(13*(mm+1)/5), Jan/Feb shifted to months 13/14
	function automatic logic [5:0] cda_month_term(input logic [3:0] m);
		logic [5:0] t;
		case (m)
			4'd0:    t = 6'd33;
			4'd1:    t = 6'd36;
			4'd2:    t = 6'd39;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd41;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cda_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cda_decode: date source decoder
// Eight-stage pipeline: splits packed/coded dates by reciprocal multiplies,
// derives year, leap flag and month/day from the day of year.
// ----------------------------------------------------------------------------
module cda_decode import cda_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_vld,
	input  wire cda_cmd_t cmd,
	output logic          out_vld,
	output cda_dec_t      dec
);

	typedef struct packed {
		logic [1:0]  op;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [17:0] ptime;
		logic        tok;
	} cry_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	cry_t        cry_s1, cry_s2, cry_s3, cry_s4, cry_s5, cry_s6, cry_s7;
	logic [23:0] coded_s1;
	logic [14:0] qk_s1, qk_s2, qk_s3;
	logic [9:0]  doy_s2, doy_s3, doy_s4, doy_s5, doy_s6, doy_s7;
	logic [7:0]  qh_s2, qh_s3;
	logic [6:0]  yy_s3;
	logic [4:0]  qt_s3;
	logic [14:0] y_s4, y_s5, y_s6, y_s7;
	logic [14:0] y1_s4, y1_s5;
	logic [7:0]  j1_s5, j1_s6, j1_s7;
	logic [6:0]  k1_s6, k1_s7;
	logic        leap_s6, leap_s7;
	logic [11:0] le_s7;
	cda_dec_t    dec_s8;

	// stage 1: year quotient, packed time
	logic [48:0] p_qk;
	logic [18:0] ptime_c;
	cry_t        cry_c;
	always_comb begin
		p_qk    = 49'(cmd.coded_date) * 49'(RECIP_1000);
		ptime_c = 19'(cmd.hour) * 19'd10000 + 19'(cmd.minute) * 19'd100 + 19'(cmd.second);
		cry_c.op    = cmd.opcode;
		cry_c.year  = cmd.year;
		cry_c.month = cmd.month;
		cry_c.day   = cmd.day;
		cry_c.ptime = ptime_c[17:0];
		cry_c.tok   = (cmd.hour <= 5'd23) && (cmd.minute <= 6'd59) &&
		              (cmd.second <= 6'd59) && (cmd.millisecond <= 10'd999);
	end

	// stage 2: day of year, century quotient
	logic [24:0] doy_full;
	logic [28:0] p_qh;
	always_comb begin
		doy_full = 25'(coded_s1) - 25'(qk_s1) * 25'd1000;
		p_qh     = 29'(qk_s1) * 29'(RECIP_100);
	end

	// stage 3: two-digit year, quotient for the century digit
	logic [14:0] yy_full;
	logic [15:0] p_qt;
	always_comb begin
		yy_full = qk_s2 - 15'(qh_s2) * 15'd100;
		p_qt    = 16'(qh_s2) * 16'(RECIP_10);
	end

	// stage 4: select the year
	logic [7:0]  c_full;
	logic [14:0] y_c;
	always_comb begin
		c_full = qh_s3 - 8'(qt_s3) * 8'd10;
		case (cry_s3.op)
			OP_PACKED: y_c = qk_s3;
			OP_CODED:  y_c = ((c_full[3:0] == 4'd0) ? YEAR_BASE19 : YEAR_BASE20) +
			                 15'(yy_s3);
			default:   y_c = {1'b0, cry_s3.year};
		endcase
	end

	// stage 5: (year + 400) / 100
	logic [28:0] p_j;
	always_comb p_j = 29'(y1_s4) * 29'(RECIP_100);

	// stage 6: year % 100 and leap flag; y%400 test uses the shifted century
	logic [14:0] k1_full;
	logic [6:0]  k1_c;
	always_comb begin
		k1_full = y1_s5 - 15'(j1_s5) * 15'd100;
		k1_c    = k1_full[6:0];
	end

	// stage 7: compare day of year against each month end
	logic [11:0] le_c;
	always_comb begin
		for (int i = 0; i < 12; i++) begin
			le_c[i] = doy_s6 <= (10'(cda_days_before(4'(i + 1), leap_s6)) +
			                     10'(cda_month_days(4'(i + 1), leap_s6)));
		end
	end

	// stage 8: first month whose end covers the day, remainder is the day
	logic [3:0] msp;
	logic [9:0] dsp;
	logic [9:0] ex;
	cda_dec_t   dec_c;
	always_comb begin
		msp = MONTH_OVF;
		for (int i = 11; i >= 0; i--) begin
			if (le_s7[i]) msp = 4'(i + 1);
		end
		ex = doy_s7 - (10'd365 + 10'(leap_s7));
		if (msp == MONTH_OVF) dsp = (ex > 10'd511) ? 10'd511 : ex;
		else                  dsp = doy_s7 - 10'(cda_days_before(msp, leap_s7));

		dec_c.year        = y_s7;
		dec_c.leap        = leap_s7;
		dec_c.ymod100     = k1_s7;
		dec_c.cent400     = j1_s7;
		dec_c.time_ok     = cry_s7.tok;
		dec_c.packed_time = cry_s7.ptime;
		if (cry_s7.op == OP_PACKED || cry_s7.op == OP_CODED) begin
			dec_c.month = msp;
			dec_c.day   = dsp[8:0];
		end else begin
			dec_c.month = cry_s7.month;
			dec_c.day   = 9'(cry_s7.day);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		cry_s1   <= cry_c;
		coded_s1 <= cmd.coded_date;
		qk_s1    <= p_qk[48:34];

		cry_s2 <= cry_s1;
		doy_s2 <= doy_full[9:0];
		qk_s2  <= qk_s1;
		qh_s2  <= p_qh[27:20];

		cry_s3 <= cry_s2;
		doy_s3 <= doy_s2;
		qk_s3  <= qk_s2;
		qh_s3  <= qh_s2;
		yy_s3  <= yy_full[6:0];
		qt_s3  <= p_qt[15:11];

		cry_s4 <= cry_s3;
		doy_s4 <= doy_s3;
		y_s4   <= y_c;
		y1_s4  <= y_c + YEAR_SHIFT;

		cry_s5 <= cry_s4;
		doy_s5 <= doy_s4;
		y_s5   <= y_s4;
		y1_s5  <= y1_s4;
		j1_s5  <= p_j[27:20];

		cry_s6  <= cry_s5;
		doy_s6  <= doy_s5;
		y_s6    <= y_s5;
		j1_s6   <= j1_s5;
		k1_s6   <= k1_c;
		leap_s6 <= ((y_s5[1:0] == 2'd0) && (k1_c != 7'd0)) ||
		           ((k1_c == 7'd0) && (j1_s5[1:0] == 2'd0));

		cry_s7  <= cry_s6;
		doy_s7  <= doy_s6;
		y_s7    <= y_s6;
		j1_s7   <= j1_s6;
		k1_s7   <= k1_s6;
		leap_s7 <= leap_s6;
		le_s7   <= le_c;

		dec_s8 <= dec_c;
	end

	assign out_vld = vld_s8;
	assign dec     = dec_s8;

endmodule
`default_nettype wire

// ===== rtl/core/calendar_date_analyzer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_analyzer: Gregorian date unit
// Decodes a direct, packed or coded date and reports validity, leap flag,
// month length, weekday, day of year, week number and packed forms.
//
//  channel | signals            | handshake
//  --------+--------------------+-----------------------------------------
//  command | start, busy, cmd   | transfer when start && !busy
//  result  | done, res          | one-cycle strobe, always taken
//
// From the command transfer to the done strobe there are eight stages of
// source decode and five of weekday and week arithmetic. A command can be
// taken every cycle; busy stays low. Reset clears the stage valid bits
// only, so nothing in flight produces a result after reset.
// ----------------------------------------------------------------------------
module calendar_date_analyzer import cda_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire cda_cmd_t cmd,
	output logic          done,
	output cda_res_t      res
);

	logic     dec_vld;
	cda_dec_t dec;

	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	cda_dec_t   dec_s9, dec_s10, dec_s11, dec_s12;
	logic [10:0] hsum_s9, hsum_s10, jsum_s9, jsum_s10;
	logic [8:0]  yd_s9, yd_s10, yd_s11, yd_s12;
	logic [4:0]  mlen_s9, mlen_s10, mlen_s11, mlen_s12;
	logic        ok_s9, ok_s10, ok_s11, ok_s12;
	logic [7:0]  hq_s10, jq_s10;
	logic [2:0]  wd_s11, wd_s12;
	logic [2:0]  jan1_s11;
	logic [9:0]  num_s11;
	logic [5:0]  wq_s12;
	logic        jle4_s12;
	cda_res_t    res_s13;

	assign busy = 1'b0;

	cda_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.cmd     (cmd),
		.out_vld (dec_vld),
		.dec     (dec)
	);

	// stage 9: month length, day of year, validity, Zeller sums
	logic       mok;
	logic [6:0] k0, kd;
	logic [7:0] j0, jd;
	logic [4:0] mlen_c;
	logic [8:0] yd_c;
	logic       ok_c;
	logic [10:0] hsum_c, jsum_c;
	always_comb begin
		mok    = (dec.month >= 4'd1) && (dec.month <= 4'd12);
		mlen_c = cda_month_days(dec.month, dec.leap);
		yd_c   = mok ? cda_days_before(dec.month, dec.leap) + dec.day : 9'd0;
		ok_c   = (dec.year >= 15'd1) && (dec.year <= YEAR_MAX) && mok &&
		         (dec.day >= 9'd1) && (dec.day <= 9'(mlen_c)) && dec.time_ok;
		// year+399 split into century and remainder from year+400
		k0 = (dec.ymod100 == 7'd0) ? 7'd99 : dec.ymod100 - 7'd1;
		j0 = (dec.ymod100 == 7'd0) ? dec.cent400 - 8'd1 : dec.cent400;
		kd = (dec.month < 4'd3) ? k0 : dec.ymod100;
		jd = (dec.month < 4'd3) ? j0 : dec.cent400;
		hsum_c = 11'(dec.day) + 11'(cda_month_term(dec.month)) + 11'(kd) +
		         11'(kd[6:2]) + 11'(jd[7:2]) + {1'b0, jd, 2'b00} + 11'(jd);
		jsum_c = 11'd37 + 11'(k0) + 11'(k0[6:2]) + 11'(j0[7:2]) +
		         {1'b0, j0, 2'b00} + 11'(j0);
	end

	// stage 10: divide the sums by 7
	logic [23:0] p_h, p_j;
	always_comb begin
		p_h = 24'(hsum_s9) * 24'(RECIP_7);
		p_j = 24'(jsum_s9) * 24'(RECIP_7);
	end

	// stage 11: remainders, shift Zeller's Saturday=0 to Sunday=0
	logic [10:0] hr_full, jr_full;
	logic [2:0]  wd_c, jan1_c;
	always_comb begin
		hr_full = hsum_s10 - 11'(hq_s10) * 11'd7;
		jr_full = jsum_s10 - 11'(jq_s10) * 11'd7;
		wd_c    = (hr_full[2:0] == 3'd0) ? 3'd6 : hr_full[2:0] - 3'd1;
		jan1_c  = (jr_full[2:0] == 3'd0) ? 3'd6 : jr_full[2:0] - 3'd1;
	end

	// stage 12: (yd + jan1 - 1) / 7
	logic [9:0]  nm1;
	logic [22:0] p_w;
	always_comb begin
		nm1 = (num_s11 == 10'd0) ? 10'd0 : num_s11 - 10'd1;
		p_w = 23'(nm1) * 23'(RECIP_7);
	end

	// stage 13: week number and packed forms
	logic [5:0]  wk;
	logic [24:0] pdate;
	cda_res_t    res_c;
	always_comb begin
		wk = wq_s12 + 6'(jle4_s12);
		if (wk == 6'd0) wk = 6'd1;
		pdate = 25'(dec_s12.year) * 25'd1000 + 25'(yd_s12);

		res_c.valid_res       = ok_s12;
		res_c.leap            = dec_s12.leap;
		res_c.month_length    = mlen_s12;
		res_c.weekday         = wd_s12;
		res_c.year_day        = yd_s12;
		res_c.week_of_year    = wk;
		res_c.packed_date_out = pdate[23:0];
		res_c.coded_date_out  = ((dec_s12.year >= YEAR_BASE20) ? CENT_WEIGHT : 18'd0) +
		                        18'(dec_s12.ymod100) * 18'd1000 + 18'(yd_s12);
		res_c.packed_time_out = dec_s12.packed_time;
		res_c.out_year        = dec_s12.year[13:0];
		res_c.out_month       = dec_s12.month;
		res_c.out_day         = dec_s12.day;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s9  <= dec_vld;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		dec_s9  <= dec;
		hsum_s9 <= hsum_c;
		jsum_s9 <= jsum_c;
		yd_s9   <= yd_c;
		mlen_s9 <= mlen_c;
		ok_s9   <= ok_c;

		dec_s10  <= dec_s9;
		hsum_s10 <= hsum_s9;
		jsum_s10 <= jsum_s9;
		hq_s10   <= p_h[22:15];
		jq_s10   <= p_j[22:15];
		yd_s10   <= yd_s9;
		mlen_s10 <= mlen_s9;
		ok_s10   <= ok_s9;

		dec_s11  <= dec_s10;
		wd_s11   <= wd_c;
		jan1_s11 <= jan1_c;
		num_s11  <= 10'(yd_s10) + 10'(jan1_c);
		yd_s11   <= yd_s10;
		mlen_s11 <= mlen_s10;
		ok_s11   <= ok_s10;

		dec_s12  <= dec_s11;
		wd_s12   <= wd_s11;
		wq_s12   <= p_w[20:15];
		jle4_s12 <= jan1_s11 <= 3'd4;
		yd_s12   <= yd_s11;
		mlen_s12 <= mlen_s11;
		ok_s12   <= ok_s11;

		res_s13 <= res_c;
	end

	assign done = vld_s13;
	assign res  = res_s13;

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.weekday <= 3'd6)
		else $error("weekday out of range");

	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.valid_res |-> res.out_month >= 4'd1 && res.out_month <= 4'd12 &&
		res.out_day >= 9'd1 && res.out_day <= 9'(res.month_length))
		else $error("valid result carries a bad date");

	a_mlen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((res.month_length == 5'd0) ==
		          (res.out_month == 4'd0 || res.out_month > 4'd12)))
		else $error("month length disagrees with month");

	a_week_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.week_of_year >= 6'd1 && res.week_of_year <= 6'd54)
		else $error("week number out of range");

endmodule
`default_nettype wire
